### design/u2h_pkg.sv
`default_nettype none
package u2h_pkg;

  // Width of a decoded code point.
  localparam int CP_W = 31;

  // Number of jobs the queue between front and back can hold.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One unit of work for the back end: a byte to pass through, or a code
  // point to render as a numeric character reference.
  typedef struct packed {
    logic            is_char;
    logic [CP_W-1:0] value;
  } job_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

### design/u2h_front.sv
`default_nettype none
module u2h_front
  import u2h_pkg::*;
#(
  parameter int MAX_SEQ_BYTES = 6
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire q_stat_t    q_stat,
  output logic            push,
  output job_t            push_job
);

  logic [CP_W-1:0] acc_r, acc_nxt;
  logic [2:0]      rem_r, rem_nxt;
  logic [3:0]      lead_len;
  logic [CP_W-1:0] cont_acc;
  logic            accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign cont_acc = {acc_r[CP_W-7:0], in_byte[5:0]};

  // Count of leading one bits of a lead byte.
  always_comb begin
    casez (in_byte)
      8'b110?????: lead_len = 4'd2;
      8'b1110????: lead_len = 4'd3;
      8'b11110???: lead_len = 4'd4;
      8'b111110??: lead_len = 4'd5;
      8'b1111110?: lead_len = 4'd6;
      8'b11111110: lead_len = 4'd7;
      8'b11111111: lead_len = 4'd8;
      default:     lead_len = 4'd0;
    endcase
  end

  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    push     = 1'b0;
    push_job = '{is_char: 1'b1, value: {{(CP_W-8){1'b0}}, in_byte}};
    if (accept) begin
      if (rem_r != 3'd0) begin
        acc_nxt = cont_acc;
        rem_nxt = rem_r - 3'd1;
        if (rem_r == 3'd1) begin
          push     = 1'b1;
          push_job = '{is_char: 1'b0, value: cont_acc};
        end
      end else if (!in_byte[7]) begin
        push = 1'b1;
      end else if (in_byte[6] && lead_len != 4'd0 && lead_len <= 4'(MAX_SEQ_BYTES)) begin
        acc_nxt = {{(CP_W-8){1'b0}}, in_byte & (8'h7F >> lead_len)};
        rem_nxt = 3'(lead_len - 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      rem_r <= 3'd0;
    end else begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

### design/u2h_queue.sv
`default_nettype none
module u2h_queue
  import u2h_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output q_stat_t   stat
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

### design/u2h_back.sv
`default_nettype none
module u2h_back
  import u2h_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire job_t       head,
  input  wire q_stat_t    q_stat,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run
);

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam int NDIG  = 10;
  localparam int BCD_W = 4 * NDIG;
  localparam int CNT_W = $clog2(CP_W);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CONV = 6'b000010,
    S_AMP  = 6'b000100,
    S_HASH = 6'b001000,
    S_DIG  = 6'b010000,
    S_SEMI = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CP_W-1:0]  sh_r, sh_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt, bcd_adj;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       idx_r, idx_nxt, top_idx;
  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r, ob_nxt;
  logic             ol_r, ol_nxt;
  logic             out_free;
  logic [3:0]       cur_dig;

  assign out_free        = !ov_r || out_ready;
  assign out_valid       = ov_r;
  assign out_byte        = ob_r;
  assign out_last_of_run = ol_r;
  assign cur_dig         = bcd_r[{idx_r, 2'b00} +: 4];

  // Add-3 correction of every digit before the next shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                   : bcd_r[4*i +: 4];
    end
  end

  // Position of the most significant nonzero digit; zero shows as one digit.
  always_comb begin
    top_idx = 4'd0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) top_idx = 4'(i);
    end
  end

  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    ov_nxt    = out_free ? 1'b0 : ov_r;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    pop       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          if (head.is_char) begin
            if (out_free) begin
              pop    = 1'b1;
              ov_nxt = 1'b1;
              ob_nxt = head.value[7:0];
              ol_nxt = 1'b1;
            end
          end else begin
            pop       = 1'b1;
            sh_nxt    = head.value;
            bcd_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = S_CONV;
          end
        end
      end
      S_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], sh_r[CP_W-1]};
        sh_nxt  = {sh_r[CP_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CP_W - 1)) state_nxt = S_AMP;
      end
      S_AMP: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = CH_AMP;
          ol_nxt    = 1'b0;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = CH_HASH;
          ol_nxt    = 1'b0;
          idx_nxt   = top_idx;
          state_nxt = S_DIG;
        end
      end
      S_DIG: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          ob_nxt = CH_ZERO | {4'd0, cur_dig};
          ol_nxt = 1'b0;
          if (idx_r == 4'd0) state_nxt = S_SEMI;
          else idx_nxt = idx_r - 4'd1;
        end
      end
      S_SEMI: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = CH_SEMI;
          ol_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    idx_r <= idx_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
  end

endmodule
`default_nettype wire

### design/utf8_to_html_char_refs.sv
// UTF-8 to HTML numeric character references. Each request carries one byte
// of UTF-8 text. A plain ASCII byte comes out unchanged with out_last_of_run
// set. A multibyte sequence (lead byte of 2 to MAX_SEQ_BYTES bytes, followed
// bytes taken unchecked) comes out, after its final byte, as "&#", the code
// point in decimal without leading zeros, and ";", with out_last_of_run set
// on the ";". Stray continuation bytes and over-long leads, 0xFE and 0xFF
// among them, are dropped silently. Timing: the front end takes one byte
// per cycle as long as its two-entry job queue has room. The back end
// works on one job at a time, taking the next only from idle. It passes
// an ASCII byte out once the output register is free. A finished sequence
// is fetched, run through shift-and-add-3 binary to decimal conversion
// (one code point bit per cycle), then sent as D + 3 bytes for D digits.
// The converter is the limit on sustained rate for non-ASCII text.
`default_nettype none
module utf8_to_html_char_refs
  import u2h_pkg::*;
#(
  parameter int MAX_SEQ_BYTES = 6
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last_of_run
);

  // Jobs flow from the decoder front end through the queue to the formatter.
  job_t    push_job;
  job_t    head;
  q_stat_t q_stat;
  logic    push;
  logic    pop;

  // Front end: tracks the open sequence and gathers the code point.
  u2h_front #(
    .MAX_SEQ_BYTES(MAX_SEQ_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  // Short job queue so the decoder can run ahead of the formatter.
  u2h_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // Back end: converts code points to decimal and drives the output register.
  u2h_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire
